FILE: rtl/sorted_array_store_unit_defines.svh
// ----------------------------------------------------------------------------
// sorted_array_store_unit_defines
// Assertion macros shared by the sorted array store RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_ARRAY_STORE_UNIT_DEFINES_SVH
`define SORTED_ARRAY_STORE_UNIT_DEFINES_SVH

// antecedent holds -> consequent holds in the next cycle
`define SAS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("sas check failed: next-cycle implication");

// antecedent holds -> consequent holds in the same cycle
`define SAS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("sas check failed: same-cycle implication");

`endif

FILE: rtl/sas_pkg.sv
// ----------------------------------------------------------------------------
// sas_pkg
// Types and constants for the sorted array store.
// ----------------------------------------------------------------------------
package sas_pkg;

  localparam int WORD_W = 32;
  localparam int POS_W  = 7;
  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_POP    = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_ERASE  = 3'd3,
    CMD_READ   = 3'd4,
    CMD_RESIZE = 3'd5,
    CMD_CLEAR  = 3'd6
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [WORD_W-1:0] value;
    logic [POS_W-1:0]         position;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_value;
    logic [POS_W-1:0]         fill_count;
    logic [STAT_W-1:0]        status;
  } out_word_t;

  // broadcast to every cell; enables are already qualified by status
  typedef struct packed {
    logic                     append;
    logic                     insert;
    logic                     erase;
    logic                     grow;
    logic signed [WORD_W-1:0] value;
  } cell_ctl_t;

endpackage

FILE: rtl/sas_cell.sv
// ----------------------------------------------------------------------------
// sas_cell
// One storage slot of the array; shifts with its neighbors on insert/erase.
// ----------------------------------------------------------------------------
module sas_cell #(
  parameter int IDX   = 0,
  parameter int CMP_W = 7
) (
  input  logic                             clk_i,
  input  sas_pkg::cell_ctl_t               ctl_i,
  input  logic [CMP_W-1:0]                 count_i,
  input  logic [CMP_W-1:0]                 pos_i,
  input  logic signed [sas_pkg::WORD_W-1:0] left_data_i,
  input  logic signed [sas_pkg::WORD_W-1:0] right_data_i,
  input  logic                             left_shift_i,
  input  logic                             right_shift_i,
  output logic signed [sas_pkg::WORD_W-1:0] data_o,
  output logic                             shift_o,
  output logic [sas_pkg::WORD_W-1:0]       rd_o
);

  localparam logic [CMP_W-1:0] MyIdx = CMP_W'(IDX);

  logic signed [sas_pkg::WORD_W-1:0] data_q, data_d;
  logic past_end, gt;

  assign past_end = (MyIdx >= count_i);
  // slots past the end always count as "larger" so the shift run reaches count
  assign gt       = past_end | ($signed(ctl_i.value) < $signed(data_q));
  assign shift_o  = gt & right_shift_i;

  always_comb begin
    data_d = data_q;
    if (ctl_i.insert && shift_o && (MyIdx <= count_i)) begin
      data_d = left_shift_i ? left_data_i : ctl_i.value;
    end else if (ctl_i.append && (MyIdx == count_i)) begin
      data_d = ctl_i.value;
    end else if (ctl_i.erase && (MyIdx >= pos_i)) begin
      data_d = right_data_i;
    end else if (ctl_i.grow && past_end && (MyIdx < pos_i)) begin
      data_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = (MyIdx == pos_i) ? data_q : '0;

endmodule

FILE: rtl/sas_rd_tree.sv
// ----------------------------------------------------------------------------
// sas_rd_tree
// Registered OR tree that folds the one selected cell word into a result.
// ----------------------------------------------------------------------------
module sas_rd_tree #(
  parameter int CAPACITY = 64
) (
  input  logic                                      clk_i,
  input  logic                                      en_i,
  input  logic [CAPACITY-1:0][sas_pkg::WORD_W-1:0]  leaf_i,
  output logic [sas_pkg::WORD_W-1:0]                word_o
);

  localparam int Grp = 8;
  localparam int NumGrp = (CAPACITY + Grp - 1) / Grp;

  logic [NumGrp-1:0][sas_pkg::WORD_W-1:0] grp_d, grp_q;

  always_comb begin
    grp_d = '0;
    for (int g = 0; g < NumGrp; g++) begin
      for (int j = 0; j < Grp; j++) begin
        if (g * Grp + j < CAPACITY) begin
          grp_d[g] = grp_d[g] | leaf_i[g * Grp + j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      grp_q <= grp_d;
    end
  end

  always_comb begin
    word_o = '0;
    for (int g = 0; g < NumGrp; g++) begin
      word_o = word_o | grp_q[g];
    end
  end

endmodule

FILE: rtl/sorted_array_store_unit.sv
// ----------------------------------------------------------------------------
// sorted_array_store_unit
// Bounded list of signed 32-bit words with append, pop, sorted insert,
// erase, read, resize and clear; one result word per command.
// ----------------------------------------------------------------------------
// Usage: a command word is taken on a rising edge with start high and busy
// low. Every command, including a failed one, yields exactly one result word,
// shown on res_o for a single cycle with done_o high once the command has
// passed stage A and the result register; the receiver cannot stall it. busy
// mirrors the stage A valid flag, so no new command is taken
// while the last one is in stage A. All shifting (sorted insert, erase) runs
// across a row of CAPACITY cells as the command is taken, and the result
// register then folds the read tree. Storage has no reset: slots at or past
// fill_count hold stale data and are never returned.
// ----------------------------------------------------------------------------
`include "sorted_array_store_unit_defines.svh"

module sorted_array_store_unit #(
  parameter int CAPACITY = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  sas_pkg::in_word_t    item_i,
  output logic                 done_o,
  output sas_pkg::out_word_t   res_o
);

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int CmpW = (CntW > sas_pkg::POS_W) ? CntW : sas_pkg::POS_W;
  localparam logic [CmpW-1:0] CapX = CmpW'(CAPACITY);

  // fill count
  logic [CntW-1:0] count_q, count_d;

  // stage A: command done in the cells, read partials captured
  logic                        a_valid_q;
  logic                        a_rd_ok_q, a_rd_ok_d;
  logic [CntW-1:0]             a_count_q;
  sas_pkg::status_e            a_status_q, a_status_d;

  // result register
  logic                        done_q;
  sas_pkg::out_word_t          res_q;

  logic                        accept;
  logic [CmpW-1:0]             pos_x, cnt_x;
  sas_pkg::cell_ctl_t          ctl;
  logic [sas_pkg::WORD_W-1:0]  rd_word;

  assign accept = start & ~busy;
  assign busy   = a_valid_q;
  assign pos_x  = CmpW'(item_i.position);
  assign cnt_x  = CmpW'(count_q);

  // Command decode: status, next count and qualified cell enables.
  always_comb begin
    count_d    = count_q;
    a_status_d = sas_pkg::ST_OK;
    a_rd_ok_d  = 1'b0;
    ctl        = '0;
    ctl.value  = item_i.value;
    case (sas_pkg::cmd_e'(item_i.cmd))
      sas_pkg::CMD_APPEND, sas_pkg::CMD_INSERT: begin
        if (cnt_x >= CapX) begin
          a_status_d = sas_pkg::ST_FULL;
        end else begin
          count_d = CntW'(count_q + CntW'(1));
          if (item_i.cmd == sas_pkg::CMD_APPEND) begin
            ctl.append = accept;
          end else begin
            ctl.insert = accept;
          end
        end
      end
      sas_pkg::CMD_POP: begin
        if (count_q == '0) begin
          a_status_d = sas_pkg::ST_EMPTY;
        end else begin
          count_d = CntW'(count_q - CntW'(1));
        end
      end
      sas_pkg::CMD_ERASE: begin
        if (pos_x >= cnt_x) begin
          a_status_d = sas_pkg::ST_RANGE;
        end else begin
          count_d   = CntW'(count_q - CntW'(1));
          ctl.erase = accept;
        end
      end
      sas_pkg::CMD_READ: begin
        if (pos_x >= cnt_x) begin
          a_status_d = sas_pkg::ST_RANGE;
        end else begin
          a_rd_ok_d = 1'b1;
        end
      end
      sas_pkg::CMD_RESIZE: begin
        if (pos_x > CapX) begin
          a_status_d = sas_pkg::ST_FULL;
        end else begin
          count_d  = CntW'(pos_x);
          ctl.grow = accept;
        end
      end
      sas_pkg::CMD_CLEAR: begin
        count_d = '0;
      end
      default: begin
        // unused code: no change
      end
    endcase
  end

  // Cell row: each cell talks to its left and right neighbor only.
  logic signed [CAPACITY-1:0][sas_pkg::WORD_W-1:0] cell_data;
  logic [CAPACITY-1:0]                             cell_shift;
  logic [CAPACITY-1:0][sas_pkg::WORD_W-1:0]        cell_rd;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [sas_pkg::WORD_W-1:0] left_data, right_data;
    logic                              left_shift, right_shift;

    if (i == 0) begin : g_first
      assign left_data  = '0;
      assign left_shift = 1'b0;
    end else begin : g_mid_l
      assign left_data  = cell_data[i-1];
      assign left_shift = cell_shift[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data  = '0;
      assign right_shift = 1'b1;
    end else begin : g_mid_r
      assign right_data  = cell_data[i+1];
      assign right_shift = cell_shift[i+1];
    end

    sas_cell #(
      .IDX   (i),
      .CMP_W (CmpW)
    ) u_cell (
      .clk_i         (clk_i),
      .ctl_i         (ctl),
      .count_i       (cnt_x),
      .pos_i         (pos_x),
      .left_data_i   (left_data),
      .right_data_i  (right_data),
      .left_shift_i  (left_shift),
      .right_shift_i (right_shift),
      .data_o        (cell_data[i]),
      .shift_o       (cell_shift[i]),
      .rd_o          (cell_rd[i])
    );
  end

  sas_rd_tree #(
    .CAPACITY (CAPACITY)
  ) u_rd_tree (
    .clk_i  (clk_i),
    .en_i   (accept),
    .leaf_i (cell_rd),
    .word_o (rd_word)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      a_valid_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      a_valid_q <= accept;
      done_q    <= a_valid_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_rd_ok_q  <= a_rd_ok_d;
      a_count_q  <= count_d;
      a_status_q <= a_status_d;
    end
    if (a_valid_q) begin
      res_q.read_value <= a_rd_ok_q ? rd_word : '0;
      res_q.fill_count <= sas_pkg::POS_W'(a_count_q);
      res_q.status     <= a_status_q;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  `SAS_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, accept, busy)
  `SAS_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, a_valid_q, done_o && !busy)
  `SAS_ASSERT_SAME(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CntW'(CAPACITY))
  `SAS_ASSERT_SAME(a_read_ok, clk_i, rst_ni, done_o && (res_o.read_value != '0),
                   res_o.status == sas_pkg::ST_OK)

endmodule
